/* rtl/ele_pkg.sv */
package ele_pkg;

    // Number of bytes the line store can hold.
    localparam int LINE_DEPTH = 32;

    // Index into the line store and width of the fill count.
    localparam int IDX_W = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int CNT_W = $clog2(LINE_DEPTH + 1);

    localparam int CHAR_W = 8;
    localparam int MAXLEN_W = 6;
    localparam logic [MAXLEN_W-1:0] MAXLEN_RESET = MAXLEN_W'(32);

    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_RETURN = 8'd13;
    localparam logic [CHAR_W-1:0] CH_TERMINATOR = 8'd0;

    // Source of the next result item.
    typedef enum logic [1:0] {
        OSEL_ECHO_CHAR,
        OSEL_ECHO_BS,
        OSEL_LINE_BYTE,
        OSEL_TERMINATOR
    } out_sel_t;

    typedef struct packed {
        logic     load_char;
        logic     idx_clear;
        logic     idx_inc;
        logic     store_char;
        logic     fill_dec;
        logic     fill_clear;
        logic     out_load;
        out_sel_t out_sel;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_return;
        logic is_backspace;
        logic fill_zero;
        logic fill_below_limit;
        logic idx_last;
        logic out_free;
    } ctrl_status_t;

endpackage

/* rtl/ele_ram.sv */
module ele_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/ele_ctrl.sv */
module ele_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  ele_pkg::ctrl_status_t status,
    output ele_pkg::ctrl_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_READ,
        S_EMIT,
        S_TERM
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        cmd.out_sel = ele_pkg::OSEL_ECHO_CHAR;
        in_stall = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load_char = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                priority if (status.is_return)
                begin
                    cmd.idx_clear = 1'b1;
                    state_next = status.fill_zero ? S_TERM : S_READ;
                end
                else if (status.is_backspace)
                begin
                    if (status.fill_zero)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (status.out_free)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.out_sel = ele_pkg::OSEL_ECHO_BS;
                        cmd.fill_dec = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    if (!status.fill_below_limit)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (status.out_free)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.out_sel = ele_pkg::OSEL_ECHO_CHAR;
                        cmd.store_char = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_READ:
            begin
                // The store address is steady here; its data shows up next cycle.
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel = ele_pkg::OSEL_LINE_BYTE;
                    cmd.idx_inc = 1'b1;
                    state_next = status.idx_last ? S_TERM : S_READ;
                end
            end
            S_TERM:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel = ele_pkg::OSEL_TERMINATOR;
                    cmd.fill_clear = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/ele_datapath.sv */
module ele_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [ele_pkg::CHAR_W-1:0]        rx_char,
    input  logic                              cfg_wr_en,
    input  logic [ele_pkg::MAXLEN_W-1:0]      cfg_wr_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [ele_pkg::CHAR_W-1:0]        out_char,
    output logic                              out_kind,
    output logic                              last_of_run,
    input  ele_pkg::ctrl_cmd_t                cmd,
    output ele_pkg::ctrl_status_t             status
);

    logic [ele_pkg::CHAR_W-1:0]   char_reg;
    logic [ele_pkg::CNT_W-1:0]    fill_reg;
    logic [ele_pkg::CNT_W-1:0]    fill_next;
    logic [ele_pkg::IDX_W-1:0]    idx_reg;
    logic [ele_pkg::IDX_W-1:0]    idx_next;
    logic [ele_pkg::MAXLEN_W-1:0] max_len_reg;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [ele_pkg::CHAR_W-1:0]   out_char_reg;
    logic [ele_pkg::CHAR_W-1:0]   out_char_next;
    logic                         out_kind_reg;
    logic                         out_kind_next;
    logic                         out_last_reg;
    logic                         out_last_next;
    logic [ele_pkg::CHAR_W-1:0]   rd_data;
    logic [ele_pkg::CNT_W-1:0]    idx_plus_one;

    ele_ram #(
        .WIDTH(ele_pkg::CHAR_W),
        .DEPTH(ele_pkg::LINE_DEPTH)
    ) u_line_store (
        .clk    (clk),
        .wr_en  (cmd.store_char),
        .wr_addr(fill_reg[ele_pkg::IDX_W-1:0]),
        .wr_data(char_reg),
        .rd_addr(idx_reg),
        .rd_data(rd_data)
    );

    assign idx_plus_one = ele_pkg::CNT_W'(idx_reg) + ele_pkg::CNT_W'(1);

    always_comb
    begin
        status.is_return = (char_reg == ele_pkg::CH_RETURN);
        status.is_backspace = (char_reg == ele_pkg::CH_BACKSPACE);
        status.fill_zero = (fill_reg == '0);
        // Both bounds are checked side by side, so the fill never exceeds the depth.
        status.fill_below_limit = (7'(fill_reg) < 7'(max_len_reg))
            && (fill_reg < ele_pkg::CNT_W'(ele_pkg::LINE_DEPTH));
        status.idx_last = (idx_plus_one == fill_reg);
        status.out_free = !out_valid_reg || !out_stall;
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (cmd.fill_clear)
        begin
            fill_next = '0;
        end
        else if (cmd.fill_dec)
        begin
            fill_next = fill_reg - ele_pkg::CNT_W'(1);
        end
        else if (cmd.store_char)
        begin
            fill_next = fill_reg + ele_pkg::CNT_W'(1);
        end

        idx_next = idx_reg;
        if (cmd.idx_clear)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_plus_one[ele_pkg::IDX_W-1:0];
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        out_char_next = out_char_reg;
        out_kind_next = out_kind_reg;
        out_last_next = out_last_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
            unique case (cmd.out_sel)
                ele_pkg::OSEL_ECHO_CHAR:
                begin
                    out_char_next = char_reg;
                    out_kind_next = 1'b0;
                    out_last_next = 1'b1;
                end
                ele_pkg::OSEL_ECHO_BS:
                begin
                    out_char_next = ele_pkg::CH_BACKSPACE;
                    out_kind_next = 1'b0;
                    out_last_next = 1'b1;
                end
                ele_pkg::OSEL_LINE_BYTE:
                begin
                    out_char_next = rd_data;
                    out_kind_next = 1'b1;
                    out_last_next = 1'b0;
                end
                ele_pkg::OSEL_TERMINATOR:
                begin
                    out_char_next = ele_pkg::CH_TERMINATOR;
                    out_kind_next = 1'b1;
                    out_last_next = 1'b1;
                end
                default:
                begin
                    out_char_next = char_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            max_len_reg <= ele_pkg::MAXLEN_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (cfg_wr_en)
            begin
                max_len_reg <= cfg_wr_data;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_char)
        begin
            char_reg <= rx_char;
        end
        idx_reg <= idx_next;
        out_char_reg <= out_char_next;
        out_kind_reg <= out_kind_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_char = out_char_reg;
    assign out_kind = out_kind_reg;
    assign last_of_run = out_last_reg;

endmodule

/* rtl/echoing_line_editor.sv */
// Channel   Handshake             Payload
// input     in_valid / in_stall   rx_char
// output    out_valid / out_stall out_char, out_kind, last_of_run
// config    cfg_wr_en             cfg_wr_data (max_length)
//
// An echoed or dropped byte is accepted in the idle state and then decided; an echo
// loads the output register once it is free. A carriage return then reads each stored
// byte from the line store and emits it, and ends with the zero terminator.
// Reset clears the fill count and sets max_length to 32; the store is not cleared.
// A stall on the output holds the result in the output register and pauses the
// sequencer; a new item is accepted while an echo still waits to be taken.
module echoing_line_editor (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [ele_pkg::CHAR_W-1:0]        rx_char,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [ele_pkg::CHAR_W-1:0]        out_char,
    output logic                              out_kind,
    output logic                              last_of_run,
    input  logic                              cfg_wr_en,
    input  logic [ele_pkg::MAXLEN_W-1:0]      cfg_wr_data
);

    // Commands flow from the sequencer to the datapath; status flows back.
    ele_pkg::ctrl_cmd_t    cmd;
    ele_pkg::ctrl_status_t status;

    // The sequencer walks one item at a time through decide, read, emit and terminator steps.
    ele_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .status  (status),
        .cmd     (cmd)
    );

    // The datapath holds the line store, fill count, limit and output register.
    ele_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_char    (rx_char),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_char   (out_char),
        .out_kind   (out_kind),
        .last_of_run(last_of_run),
        .cmd        (cmd),
        .status     (status)
    );

endmodule

/* tb/sv/tb_echoing_line_editor.sv */
`timescale 1ns / 1ps

// Testbench for the echoing line editor.
//
// A sender task offers received bytes one item at a time, and a line model in
// this file predicts the echo and line-delivery results of every accepted item.
// A separate checker process compares each result taken from the block with the
// oldest prediction, field by field. Both channels idle at random, and one test
// holds the output stalled for a long stretch so the block backs up its input.
module tb_echoing_line_editor;

    // One predicted result, in the order the block must deliver it.
    typedef struct packed {
        logic [ele_pkg::CHAR_W-1:0] ch;
        logic                       kind;
        logic                       last;
    } line_result_t;

    localparam logic KIND_ECHO = 1'b0;
    localparam logic KIND_LINE = 1'b1;

    // A dropped byte keeps the block busy with no result, so a register write
    // also waits out a settle stretch after the last expected result.
    localparam int SETTLE_CYCLES = 8;
    // Longest legal quiet stretch: a long receiver stall plus a long sender gap,
    // or the deliberate hold-off below. The limit is several times either.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PRESSURE_HOLD = 150;
    localparam int RANDOM_ITEMS = 150;
    localparam int PHASE_ITEMS = 22;

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_stall;
    logic [ele_pkg::CHAR_W-1:0]   rx_char;
    logic                         out_valid;
    logic                         out_stall;
    logic [ele_pkg::CHAR_W-1:0]   out_char;
    logic                         out_kind;
    logic                         last_of_run;
    logic                         cfg_wr_en;
    logic [ele_pkg::MAXLEN_W-1:0] cfg_wr_data;

    // State of the line model: kept bytes, how many, and the length limit.
    logic [ele_pkg::CHAR_W-1:0]   model_line [ele_pkg::LINE_DEPTH];
    logic [ele_pkg::CNT_W-1:0]    model_fill;
    logic [ele_pkg::MAXLEN_W-1:0] model_max_len;
    line_result_t                 expected_out[$];

    int failures = 0;
    int items_sent = 0;
    // When set, neither side inserts gaps or stalls.
    bit quiet = 1'b0;
    // Number of cycles the receiver is asked to hold off; it clears this itself.
    int hold_request = 0;

    echoing_line_editor dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_char     (rx_char),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_char    (out_char),
        .out_kind    (out_kind),
        .last_of_run (last_of_run),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Line model. A carriage return delivers every kept byte and then a zero
    // terminator marked last. A backspace only acts on a non-empty line. Any
    // other byte is kept and echoed while the fill is below the smaller of the
    // configured maximum and the store depth; otherwise it is silently dropped.
    function automatic void predict_edit(input logic [ele_pkg::CHAR_W-1:0] c);
        int limit;
        int kept;
        limit = (int'(model_max_len) < ele_pkg::LINE_DEPTH) ? int'(model_max_len)
            : ele_pkg::LINE_DEPTH;
        kept = (int'(model_fill) < ele_pkg::LINE_DEPTH) ? int'(model_fill)
            : ele_pkg::LINE_DEPTH;
        if (c == ele_pkg::CH_RETURN)
        begin
            for (int i = 0; i < kept; i++)
                expected_out.push_back(line_result_t'{model_line[i], KIND_LINE, 1'b0});
            expected_out.push_back(line_result_t'{ele_pkg::CH_TERMINATOR, KIND_LINE, 1'b1});
            model_fill = '0;
        end
        else if (c == ele_pkg::CH_BACKSPACE)
        begin
            if (model_fill != '0)
            begin
                model_fill = model_fill - ele_pkg::CNT_W'(1);
                expected_out.push_back(line_result_t'{ele_pkg::CH_BACKSPACE, KIND_ECHO, 1'b1});
            end
        end
        else if (int'(model_fill) < limit)
        begin
            model_line[model_fill[ele_pkg::IDX_W-1:0]] = c;
            model_fill = model_fill + ele_pkg::CNT_W'(1);
            expected_out.push_back(line_result_t'{c, KIND_ECHO, 1'b1});
        end
    endfunction

    // Offers one byte, possibly after a random gap, and waits until the block
    // takes it. Valid is left high after acceptance so back-to-back items keep
    // it asserted; settle_idle lowers it when a phase ends.
    task automatic send_char(input logic [ele_pkg::CHAR_W-1:0] c);
        int gap;
        int pick;
        gap = 0;
        if (!quiet)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
                gap = 0;
            else if (pick < 92)
                gap = $urandom_range(1, 3);
            else
                gap = $urandom_range(10, 40);
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_char <= c;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        predict_edit(c);
        items_sent++;
    endtask

    // Stops offering items and waits until every predicted result has been
    // taken, plus a settle stretch for any dropped byte still being processed.
    task automatic settle_idle();
        in_valid <= 1'b0;
        while (expected_out.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_max_length(input logic [ele_pkg::MAXLEN_W-1:0] value);
        settle_idle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        model_max_len = value;
    endtask

    // Types one line of random content and ends it with a carriage return.
    // Most lines are short; a few are long enough to reach or run past the store depth.
    // Some bytes are full-range noise, which may include stray control codes.
    task automatic type_line();
        int len;
        int pick;
        len = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 10) : $urandom_range(28, 40);
        for (int k = 0; k < len; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 12)
                send_char(ele_pkg::CH_BACKSPACE);
            else if (pick < 20)
                send_char(ele_pkg::CHAR_W'($urandom_range(0, 255)));
            else
                send_char(ele_pkg::CHAR_W'($urandom_range(32, 126)));
        end
        send_char(ele_pkg::CH_RETURN);
    endtask

    // Runs with the limit left at its reset value: backspace and return on an
    // empty line, the zero byte, extreme and alternating bit patterns, and the
    // neighbors of the two control codes.
    task automatic test_directed_edits();
        send_char(ele_pkg::CH_BACKSPACE);
        send_char(ele_pkg::CH_RETURN);
        send_char(8'h00);
        send_char(8'hFF);
        send_char(8'h55);
        send_char(8'hAA);
        send_char(ele_pkg::CH_BACKSPACE);
        send_char(8'h07);
        send_char(8'h09);
        send_char(8'h0C);
        send_char(8'h0E);
        send_char(ele_pkg::CH_RETURN);
        send_char(ele_pkg::CH_BACKSPACE);
        settle_idle();
    endtask

    // A full line drops bytes; a limit lowered below the fill keeps the stored
    // bytes but drops new ones until backspaces bring the fill under the limit;
    // a limit of zero leaves every line empty.
    task automatic test_length_limits();
        write_max_length(ele_pkg::MAXLEN_W'(3));
        send_char("a");
        send_char("b");
        send_char("c");
        send_char("d");
        send_char(ele_pkg::CH_RETURN);

        write_max_length(ele_pkg::MAXLEN_W'(32));
        send_char("w");
        send_char("x");
        send_char("y");
        write_max_length(ele_pkg::MAXLEN_W'(2));
        send_char("q");
        send_char(ele_pkg::CH_BACKSPACE);
        send_char("r");
        send_char(ele_pkg::CH_BACKSPACE);
        send_char("s");
        send_char(ele_pkg::CH_RETURN);

        write_max_length(ele_pkg::MAXLEN_W'(0));
        send_char("k");
        send_char(ele_pkg::CH_RETURN);
        settle_idle();
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering
    // a line with no gaps, so the output register and then the input back up.
    task automatic test_backpressure();
        write_max_length(ele_pkg::MAXLEN_W'(32));
        hold_request = PRESSURE_HOLD;
        while (out_stall !== 1'b1)
            @(posedge clk);
        quiet = 1'b1;
        for (int k = 0; k < 20; k++)
            send_char(ele_pkg::CHAR_W'($urandom_range(32, 126)));
        send_char(ele_pkg::CH_RETURN);
        quiet = 1'b0;
        settle_idle();
    endtask

    // Random lines under a series of limits, the extremes among them: the
    // widest value (saturates at the store depth), zero, one, and just above
    // the depth. Every fourth phase runs with no idling on either side.
    task automatic test_random_lines();
        logic [ele_pkg::MAXLEN_W-1:0] limits [8];
        int target;
        int phase;
        int phase_start;
        limits = '{6'd32, 6'd63, 6'd0, 6'd1, 6'd7, 6'd33, 6'd31, 6'd16};
        target = items_sent + RANDOM_ITEMS;
        phase = 0;
        while (items_sent < target)
        begin
            if (phase < 8)
                write_max_length(limits[phase]);
            else
                write_max_length(ele_pkg::MAXLEN_W'($urandom_range(0, 63)));
            quiet = (phase % 4 == 3);
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
                type_line();
            quiet = 1'b0;
            phase++;
        end
        settle_idle();
    endtask

    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        rx_char <= '0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        model_fill = '0;
        model_max_len = ele_pkg::MAXLEN_RESET;
        for (int i = 0; i < ele_pkg::LINE_DEPTH; i++)
            model_line[i] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_edits();
        test_length_limits();
        test_backpressure();
        test_random_lines();

        if (failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Receiver: picks stall stretches of random length, mostly short with a few
    // long ones. A hold-off request takes priority and is counted here.
    initial
    begin
        int left;
        int pick;
        logic stall_now;
        left = 0;
        stall_now = 1'b0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold_request) @(posedge clk);
                hold_request = 0;
                stall_now = 1'b0;
                left = 0;
                out_stall <= 1'b0;
            end
            else
            begin
                if (left == 0)
                begin
                    pick = $urandom_range(0, 99);
                    if (quiet || pick < 60)
                    begin
                        stall_now = 1'b0;
                        left = $urandom_range(1, 6);
                    end
                    else if (pick < 92)
                    begin
                        stall_now = 1'b1;
                        left = $urandom_range(1, 3);
                    end
                    else
                    begin
                        stall_now = 1'b1;
                        left = $urandom_range(15, 50);
                    end
                end
                out_stall <= stall_now;
                left--;
            end
        end
    end

    // Checker: every result taken from the block must match the oldest
    // prediction. A result with nothing predicted is a failure too.
    initial
    begin
        line_result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
            begin
                if (expected_out.size() == 0)
                begin
                    $error("unexpected result: out_char %0d out_kind %0d last_of_run %0d",
                           out_char, out_kind, last_of_run);
                    failures++;
                end
                else
                begin
                    want = expected_out.pop_front();
                    if (out_char !== want.ch)
                    begin
                        $error("out_char: expected %0d, actual %0d", want.ch, out_char);
                        failures++;
                    end
                    if (out_kind !== want.kind)
                    begin
                        $error("out_kind: expected %0d, actual %0d", want.kind, out_kind);
                        failures++;
                    end
                    if (last_of_run !== want.last)
                    begin
                        $error("last_of_run: expected %0d, actual %0d",
                               want.last, last_of_run);
                        failures++;
                    end
                end
            end
        end
    end

    // Watchdog: ends the run if no item moves on either channel for too long.
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid === 1'b1 && in_stall === 1'b0) ||
                (out_valid === 1'b1 && out_stall === 1'b0))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("*** FAILED ***");
        $finish;
    end

endmodule

/* files.f */
rtl/ele_pkg.sv
rtl/ele_ram.sv
rtl/ele_ctrl.sv
rtl/ele_datapath.sv
rtl/echoing_line_editor.sv
tb/sv/tb_echoing_line_editor.sv
